[rtl/ilid_pkg.sv]
package ilid_pkg;

  // storage depth and field widths
  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int LEN_W    = 7;
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = DEPTH / GRP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_SET    = 3'd4
  } cmd_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    COP_NOP    = 2'd0,
    COP_WRITE  = 2'd1,
    COP_INSERT = 2'd2,
    COP_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [LEN_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic [LEN_W-1:0]   len;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_t;

endpackage

[rtl/ilid_cell.sv]
module ilid_cell (
  input  logic                       clk,
  input  logic [ilid_pkg::IDX_W-1:0] cell_idx,
  input  ilid_pkg::cell_cmd_t        cmd,
  input  logic [ilid_pkg::VAL_W-1:0] left_data,
  input  logic [ilid_pkg::VAL_W-1:0] right_data,
  output logic [ilid_pkg::VAL_W-1:0] data,
  output logic [ilid_pkg::VAL_W-1:0] hit_data
);
  import ilid_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic [LEN_W-1:0] idx;
  logic             at_pos;
  logic             above_pos;
  logic             is_last;

  assign idx       = LEN_W'(cell_idx);
  assign at_pos    = (idx == cmd.pos);
  assign above_pos = (idx > cmd.pos);
  assign is_last   = ((idx + LEN_W'(1)) == cmd.len);

  // next entry value from the broadcast operation and the neighbors
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      COP_WRITE: begin
        if (at_pos) data_nxt = cmd.val;
      end
      COP_INSERT: begin
        if (at_pos) data_nxt = cmd.val;
        else if (above_pos) data_nxt = left_data;
      end
      COP_DELETE: begin
        if (is_last) data_nxt = '0;
        else if ((at_pos || above_pos) && (idx < cmd.len)) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  // old entry offered to the read gather when this cell is addressed
  assign hit_data = at_pos ? data_r : '0;

endmodule

[rtl/ilid_gather.sv]
module ilid_gather (
  input  logic                       clk,
  input  logic                       capture,
  input  logic [ilid_pkg::VAL_W-1:0] hit_data [ilid_pkg::DEPTH],
  output logic [ilid_pkg::VAL_W-1:0] rd_value
);
  import ilid_pkg::*;

  logic [VAL_W-1:0] grp_r   [NGRP];
  logic [VAL_W-1:0] grp_nxt [NGRP];

  // first level: or of each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] | hit_data[g*GRP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < NGRP; g++) grp_r[g] <= grp_nxt[g];
    end
  end

  // second level: or of the group registers
  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGRP; g++) rd_value = rd_value | grp_r[g];
  end

endmodule

[rtl/indexed_list_insert_delete.sv]
// channel | direction | handshake          | payload
// in_     | request   | in_tvalid/tready   | in_tdata: cmd, position, value
// out_    | result    | out_tvalid/tready  | out_tdata: result_value, status, count
// cfg_    | register  | psel/penable       | capacity at byte address 0
//
// the row of entry cells shifts or writes at the accept edge, while the addressed
// old entry is captured into the group registers of a two-level or tree; the
// group registers are then or-ed into the output register once the output is free.
// a new request is taken only after the previous result is loaded into the output register.
// reset clears the length, the capacity returns to 64; entry cells keep no reset.
// a stalled output holds the result and blocks the next request only in the collect state.
module indexed_list_insert_delete (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cmd[2:0], position[9:3], value[41:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_value[31:0], status[33:32], count[40:34]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ilid_pkg::*;

  // configuration register
  logic [LEN_W-1:0] cap_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LEN_W'(64);
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  // request fields
  logic [CMD_W-1:0] in_cmd;
  logic [LEN_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  logic             accept;

  assign in_cmd = in_tdata[2:0];
  assign in_pos = in_tdata[9:3];
  assign in_val = in_tdata[41:10];

  state_t           state_r, state_nxt;
  logic             out_valid_r;
  logic [47:0]      out_data_r;
  logic [LEN_W-1:0] len_r;
  logic [ST_W-1:0]  st_r;
  logic             use_rd_r;
  logic [VAL_W-1:0] resv_r;
  logic             load_out;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // decode: status, new length and the cell operation
  logic [LEN_W-1:0] eff_cap;
  logic             full;
  cell_cmd_t        ccmd;
  status_e_t        st_d;
  logic [LEN_W-1:0] len_d;
  logic             use_rd_d;
  logic [VAL_W-1:0] resv_d;

  assign eff_cap = (cap_r > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : cap_r;
  assign full    = (len_r >= eff_cap);

  always_comb begin
    ccmd.op  = COP_NOP;
    ccmd.pos = in_pos;
    ccmd.val = in_val;
    ccmd.len = len_r;
    st_d     = ST_OK;
    len_d    = len_r;
    use_rd_d = 1'b0;
    resv_d   = '0;
    unique case (in_cmd)
      CMD_APPEND: begin
        if (full) st_d = ST_FULL;
        else begin
          ccmd.op  = COP_WRITE;
          ccmd.pos = len_r;
          len_d    = len_r + LEN_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) st_d = ST_FULL;
        else if (in_pos > len_r) st_d = ST_RANGE;
        else begin
          ccmd.op = COP_INSERT;
          len_d   = len_r + LEN_W'(1);
        end
      end
      CMD_DELETE: begin
        if (in_pos >= len_r) st_d = ST_RANGE;
        else begin
          ccmd.op  = COP_DELETE;
          len_d    = len_r - LEN_W'(1);
          use_rd_d = 1'b1;
        end
      end
      CMD_GET: begin
        if (in_pos >= len_r) st_d = ST_RANGE;
        else use_rd_d = 1'b1;
      end
      CMD_SET: begin
        if (in_pos >= len_r) st_d = ST_RANGE;
        else begin
          ccmd.op = COP_WRITE;
          resv_d  = in_val;
        end
      end
      default: st_d = ST_OK;
    endcase
    if (!accept) ccmd.op = COP_NOP;
  end

  // row of entry cells
  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] cell_hit  [DEPTH];
  logic [VAL_W-1:0] rd_value;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end
    ilid_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .cmd        (ccmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .hit_data   (cell_hit[g])
    );
  end

  ilid_gather u_gather (
    .clk      (clk),
    .capture  (accept),
    .hit_data (cell_hit),
    .rd_value (rd_value)
  );

  // request bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept) begin
      len_r <= len_d;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r     <= st_d;
      use_rd_r <= use_rd_d;
      resv_r   <= resv_d;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_GATHER;
      end
      S_GATHER: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {7'd0, len_r, st_r, (use_rd_r ? rd_value : resv_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
